/* rtl/core/bqf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared widths, register indexes, sequencer states and control structs for
// the biquad IIR filter.
// ----------------------------------------------------------------------------
package bqf_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int COEFF_FRAC_BITS = 14;
  localparam int W_BITS          = SAMPLE_BITS + 4;
  localparam int COEF_BITS       = COEFF_FRAC_BITS + 4;
  localparam int PROD_BITS       = COEF_BITS + W_BITS;
  localparam int ACC_BITS        = PROD_BITS + 2;
  localparam int RND_BITS        = ACC_BITS - COEFF_FRAC_BITS;

  localparam int NUM_REGS  = 5;
  localparam int IDX_BITS  = 3;
  localparam int ADDR_BITS = IDX_BITS + 2;
  localparam int DATA_BITS = 32;

  localparam logic [IDX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_A1 = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_A2 = 3'd4;

  localparam logic signed [COEF_BITS-1:0] B0_RESET = COEF_BITS'(1 << COEFF_FRAC_BITS);

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [W_BITS-1:0]    wval_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  typedef struct packed {
    logic mul_en;
    logic load;
    logic accum;
    logic sub;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A2,
    ST_WSUM,
    ST_WRND,
    ST_B0,
    ST_B2,
    ST_YSUM,
    ST_YRND
  } seq_state_t;

endpackage

/* rtl/core/bqf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_if
// Valid/ready stream interfaces for filter input samples and results.
// ----------------------------------------------------------------------------
interface bqf_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [bqf_pkg::SAMPLE_BITS-1:0]   sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqf_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [bqf_pkg::SAMPLE_BITS-1:0]   sample_out;
  logic                                     clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

/* rtl/core/bqf_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_regs
// APB-style coefficient register file (five signed Q3.14 registers).
// ----------------------------------------------------------------------------
module bqf_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bqf_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [bqf_pkg::DATA_BITS-1:0]      pwdata,
  output logic [bqf_pkg::DATA_BITS-1:0]      prdata,
  output logic                               pready,
  output bqf_pkg::coef_set_t                 coefs
);

  logic [bqf_pkg::IDX_BITS-1:0] idx;
  logic                         wr;
  bqf_pkg::coef_t               wval;
  bqf_pkg::coef_t               rval;

  assign idx    = paddr[bqf_pkg::ADDR_BITS-1:2];
  assign wr     = psel && penable && pwrite;
  assign wval   = pwdata[bqf_pkg::COEF_BITS-1:0];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.b0 <= bqf_pkg::B0_RESET;
      coefs.b1 <= '0;
      coefs.b2 <= '0;
      coefs.a1 <= '0;
      coefs.a2 <= '0;
    end else if (wr) begin
      case (idx)
        bqf_pkg::REG_B0: coefs.b0 <= wval;
        bqf_pkg::REG_B1: coefs.b1 <= wval;
        bqf_pkg::REG_B2: coefs.b2 <= wval;
        bqf_pkg::REG_A1: coefs.a1 <= wval;
        bqf_pkg::REG_A2: coefs.a2 <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bqf_pkg::REG_B0: rval = coefs.b0;
      bqf_pkg::REG_B1: rval = coefs.b1;
      bqf_pkg::REG_B2: rval = coefs.b2;
      bqf_pkg::REG_A1: rval = coefs.a1;
      bqf_pkg::REG_A2: rval = coefs.a2;
      default:         rval = '0;
    endcase
  end

  // sign-extend onto the 32-bit read bus
  assign prdata = {{(bqf_pkg::DATA_BITS-bqf_pkg::COEF_BITS){rval[bqf_pkg::COEF_BITS-1]}},
                   rval};

endmodule

/* rtl/core/bqf_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_mac
// Shared multiply-accumulate unit: registered 18x20 product, 40-bit
// accumulator with load, add and subtract.
// ----------------------------------------------------------------------------
module bqf_mac (
  input  logic                                   clk,
  input  bqf_pkg::mac_ctl_t                      ctl,
  input  bqf_pkg::coef_t                         coef_op,
  input  bqf_pkg::wval_t                         data_op,
  input  logic signed [bqf_pkg::ACC_BITS-1:0]    load_val,
  output logic signed [bqf_pkg::ACC_BITS-1:0]    acc
);

  logic signed [bqf_pkg::PROD_BITS-1:0] prod;
  logic signed [bqf_pkg::ACC_BITS-1:0]  prod_ext;
  logic signed [bqf_pkg::ACC_BITS-1:0]  acc_next;

  assign prod_ext = {{(bqf_pkg::ACC_BITS-bqf_pkg::PROD_BITS){prod[bqf_pkg::PROD_BITS-1]}},
                     prod};

  always_comb begin
    acc_next = acc;
    if (ctl.load) begin
      acc_next = load_val;
    end else if (ctl.accum) begin
      acc_next = ctl.sub ? (acc - prod_ext) : (acc + prod_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= coef_op * data_op;
    end
    acc <= acc_next;
  end

endmodule

/* rtl/core/bqf_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_seq
// Sequencer and state for one biquad sample: operand selection, rounding,
// saturation, delay line and the result register.
// ----------------------------------------------------------------------------
module bqf_seq (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bqf_pkg::coef_set_t                     coefs,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [bqf_pkg::SAMPLE_BITS-1:0] sample_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [bqf_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                                   clipped,
  output bqf_pkg::mac_ctl_t                      mac_ctl,
  output bqf_pkg::coef_t                         coef_op,
  output bqf_pkg::wval_t                         data_op,
  output logic signed [bqf_pkg::ACC_BITS-1:0]    load_val,
  input  logic signed [bqf_pkg::ACC_BITS-1:0]    acc
);

  localparam int XPAD = bqf_pkg::ACC_BITS - bqf_pkg::SAMPLE_BITS - bqf_pkg::COEFF_FRAC_BITS;
  localparam logic signed [bqf_pkg::ACC_BITS-1:0] HALF_LSB =
    bqf_pkg::ACC_BITS'(1 << (bqf_pkg::COEFF_FRAC_BITS - 1));
  localparam int WTOP = bqf_pkg::RND_BITS - bqf_pkg::W_BITS + 1;
  localparam int YTOP = bqf_pkg::RND_BITS - bqf_pkg::SAMPLE_BITS + 1;

  bqf_pkg::seq_state_t state, state_next;

  bqf_pkg::wval_t w1, w2, wq;
  logic           w_sat;
  logic           accept, finish;

  logic signed [bqf_pkg::ACC_BITS-1:0] rsum;
  logic signed [bqf_pkg::RND_BITS-1:0] rnd;
  logic [WTOP-1:0]                     wtop;
  logic [YTOP-1:0]                     ytop;
  logic                                wsat_now, ysat_now;
  bqf_pkg::wval_t                      wsat_val;
  logic signed [bqf_pkg::SAMPLE_BITS-1:0] ysat_val;

  assign accept = in_valid && in_ready;

  // round half up then clamp; the top bits of the rounded sum show overflow
  assign rsum     = acc + HALF_LSB;
  assign rnd      = rsum[bqf_pkg::ACC_BITS-1:bqf_pkg::COEFF_FRAC_BITS];
  assign wtop     = rnd[bqf_pkg::RND_BITS-1:bqf_pkg::W_BITS-1];
  assign ytop     = rnd[bqf_pkg::RND_BITS-1:bqf_pkg::SAMPLE_BITS-1];
  assign wsat_now = !((&wtop) || !(|wtop));
  assign ysat_now = !((&ytop) || !(|ytop));
  assign wsat_val = wsat_now
    ? {rnd[bqf_pkg::RND_BITS-1], {(bqf_pkg::W_BITS-1){~rnd[bqf_pkg::RND_BITS-1]}}}
    : rnd[bqf_pkg::W_BITS-1:0];
  assign ysat_val = ysat_now
    ? {rnd[bqf_pkg::RND_BITS-1], {(bqf_pkg::SAMPLE_BITS-1){~rnd[bqf_pkg::RND_BITS-1]}}}
    : rnd[bqf_pkg::SAMPLE_BITS-1:0];

  assign load_val = {{XPAD{sample_in[bqf_pkg::SAMPLE_BITS-1]}}, sample_in,
                     {bqf_pkg::COEFF_FRAC_BITS{1'b0}}};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bqf_pkg::ST_IDLE: if (accept) state_next = bqf_pkg::ST_A2;
      bqf_pkg::ST_A2:   state_next = bqf_pkg::ST_WSUM;
      bqf_pkg::ST_WSUM: state_next = bqf_pkg::ST_WRND;
      bqf_pkg::ST_WRND: state_next = bqf_pkg::ST_B0;
      bqf_pkg::ST_B0:   state_next = bqf_pkg::ST_B2;
      bqf_pkg::ST_B2:   state_next = bqf_pkg::ST_YSUM;
      bqf_pkg::ST_YSUM: state_next = bqf_pkg::ST_YRND;
      bqf_pkg::ST_YRND: if (!out_valid || out_ready) state_next = bqf_pkg::ST_IDLE;
      default:          state_next = bqf_pkg::ST_IDLE;
    endcase
  end

  // outputs: operand select and MAC control
  always_comb begin
    mac_ctl  = '0;
    coef_op  = coefs.a1;
    data_op  = w1;
    in_ready = 1'b0;
    finish   = 1'b0;
    case (state)
      bqf_pkg::ST_IDLE: begin
        // no request is taken while reset is held
        in_ready       = !rst;
        mac_ctl.mul_en = 1'b1;
        mac_ctl.load   = accept;
      end
      bqf_pkg::ST_A2: begin
        coef_op        = coefs.a2;
        data_op        = w2;
        mac_ctl.mul_en = 1'b1;
        mac_ctl.accum  = 1'b1;
        mac_ctl.sub    = 1'b1;
      end
      bqf_pkg::ST_WSUM: begin
        mac_ctl.accum = 1'b1;
        mac_ctl.sub   = 1'b1;
      end
      bqf_pkg::ST_WRND: begin
        // acc is read for w here; clear it while b1*w1 starts
        coef_op        = coefs.b1;
        data_op        = w1;
        mac_ctl.mul_en = 1'b1;
        mac_ctl.load   = 1'b1;
      end
      bqf_pkg::ST_B0: begin
        coef_op        = coefs.b0;
        data_op        = wq;
        mac_ctl.mul_en = 1'b1;
        mac_ctl.accum  = 1'b1;
      end
      bqf_pkg::ST_B2: begin
        coef_op        = coefs.b2;
        data_op        = w2;
        mac_ctl.mul_en = 1'b1;
        mac_ctl.accum  = 1'b1;
      end
      bqf_pkg::ST_YSUM: begin
        mac_ctl.accum = 1'b1;
      end
      bqf_pkg::ST_YRND: begin
        finish = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  // the clear in ST_WRND goes through the load path; the top level zeroes
  // load_val whenever the input side is not ready

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bqf_pkg::ST_IDLE;
      out_valid <= 1'b0;
      w1        <= '0;
      w2        <= '0;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid <= 1'b1;
        w2        <= w1;
        w1        <= wq;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == bqf_pkg::ST_WRND) begin
      wq    <= wsat_val;
      w_sat <= wsat_now;
    end
    if (finish) begin
      sample_out <= ysat_val;
      clipped    <= w_sat || ysat_now;
    end
  end

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == bqf_pkg::ST_A2)
    else $error("accepted sample did not start the MAC sequence");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid)
    else $error("result not presented after finish");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && state == bqf_pkg::ST_YRND) |=> state == bqf_pkg::ST_YRND)
    else $error("sequencer left final step while result was pending");

  a_delay_hold: assert property (@(posedge clk) disable iff (rst)
    (state != bqf_pkg::ST_YRND) |=> $stable(w1) && $stable(w2))
    else $error("delay line changed outside the final step");

endmodule

/* rtl/core/biquad_iir_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_iir_filter
// Direct form II biquad section, Q1.15 samples, Q3.14 coefficients, one
// shared multiplier-accumulator stepped by a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+-------------------------------
//  samples   | in  | valid/ready            | sample_in  (s16, Q1.15)
//  results   | out | valid/ready            | sample_out (s16, Q1.15), clipped
//  apb       | in  | psel/penable, pready=1 | 5 coef regs @ 4*i, 18b signed
//
//  Each request runs through the accept cycle and 7 sequencer steps, since
//  five products go through the single registered 18x20 multiplier.
//  in_ready is high only in the idle state; the sequencer runs unattended
//  after accept. The result sits in an output register, so a new sample is
//  accepted while it waits; the final step stalls only if the previous result
//  is still untaken. Synchronous reset restores b0 = 1.0, others 0, and
//  clears both delays.
//
module biquad_iir_filter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bqf_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [bqf_pkg::DATA_BITS-1:0]  pwdata,
  output logic [bqf_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  bqf_in_if.sink                         samples,
  bqf_out_if.source                      results
);

  bqf_pkg::coef_set_t coefs;
  bqf_pkg::mac_ctl_t  mac_ctl;
  bqf_pkg::coef_t     coef_op;
  bqf_pkg::wval_t     data_op;
  logic signed [bqf_pkg::ACC_BITS-1:0] seq_load;
  logic signed [bqf_pkg::ACC_BITS-1:0] mac_load;
  logic signed [bqf_pkg::ACC_BITS-1:0] acc;

  // coefficient registers
  bqf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  // sequencer, delay line, round/saturate and result register
  bqf_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .coefs      (coefs),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .sample_in  (samples.sample_in),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .sample_out (results.sample_out),
    .clipped    (results.clipped),
    .mac_ctl    (mac_ctl),
    .coef_op    (coef_op),
    .data_op    (data_op),
    .load_val   (seq_load),
    .acc        (acc)
  );

  // the load path seeds the w sum with x and clears the accumulator for y;
  // the y clear happens with the multiplier busy, i.e. not in the idle state
  assign mac_load = samples.ready ? seq_load : '0;

  // shared multiplier-accumulator
  bqf_mac u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .coef_op  (coef_op),
    .data_op  (data_op),
    .load_val (mac_load),
    .acc      (acc)
  );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the biquad IIR filter. A directed table runs
// first: pass-through after reset, coefficient extremes, ignored writes,
// truncated register data and saturation of the internal w value. After
// that come randomized phases over several coefficient sets and idle/stall
// mixes, and one long receiver hold-off. Each accepted request is scored
// against typed values or a bit-accurate fixed-point predictor in the bench.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic signed [bqf_pkg::SAMPLE_BITS-1:0] smp_t;
  typedef logic [bqf_pkg::ADDR_BITS-1:0]          addr_t;
  typedef logic [bqf_pkg::DATA_BITS-1:0]          data_t;

  // one filtered sample as it should leave the results channel
  typedef struct {
    smp_t y;
    logic clip;
  } filt_out_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // directed stimulus row: a register write or a sample; for samples the
  // expected output is typed in when 'typed' is set, else it is predicted
  typedef struct {
    row_kind_t kind;
    addr_t     addr;
    data_t     data;
    smp_t      x;
    bit        typed;
    smp_t      y;
    logic      clip;
  } dir_row_t;

  // register indexes past the end of the map; writes there must be dropped
  localparam logic [bqf_pkg::IDX_BITS-1:0] REG_NONE_LO = 3'd5;
  localparam logic [bqf_pkg::IDX_BITS-1:0] REG_NONE_HI = 3'd7;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 170;
  localparam int SETTLE_CYC  = 12;   // one request's sequencer run plus margin
  localparam int HOLD_CYC    = 300;
  localparam int DIR_ROWS    = 35;

  // ---------------------------------------------------------------------------
  // Directed table. Reset state is b0 = 1.0, rest 0, so y == x exactly.
  // Extreme b0 values with zero feedback saturate the output at once.
  // Later rows drive w into saturation through fb_a1 = -8.0 and put a1, a2,
  // b1 and b2 at their limits; those rows go through the predictor.
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_SAMPLE, '0, '0, 16'sd0,        1'b1, 16'sd0,        1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF,     1'b1, 16'sh7FFF,     1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh8000,     1'b1, 16'sh8000,     1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sd1,        1'b1, 16'sd1,        1'b0},
    '{ROW_SAMPLE, '0, '0, -16'sd1,       1'b1, -16'sd1,       1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sd21845,    1'b1, 16'sd21845,    1'b0},
    // writes outside the register map: no effect on the pass-through
    '{ROW_WRITE, {REG_NONE_LO, 2'b00}, 32'h0000_1234, '0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, {REG_NONE_HI, 2'b00}, 32'hFFFF_FFFF, '0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, -16'sd21846,   1'b1, -16'sd21846,   1'b0},
    // b0 at its positive limit (just under 8.0)
    '{ROW_WRITE, {bqf_pkg::REG_B0, 2'b00}, 32'h0001_FFFF, '0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF,     1'b1, 16'sh7FFF,     1'b1},
    '{ROW_SAMPLE, '0, '0, 16'sh8000,     1'b1, 16'sh8000,     1'b1},
    '{ROW_SAMPLE, '0, '0, 16'sd2,        1'b0, '0,            1'b0},
    // b0 at its negative limit (-8.0)
    '{ROW_WRITE, {bqf_pkg::REG_B0, 2'b00}, 32'h0002_0000, '0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF,     1'b1, 16'sh8000,     1'b1},
    '{ROW_SAMPLE, '0, '0, 16'sh8000,     1'b1, 16'sh7FFF,     1'b1},
    // upper data bits are dropped: low 18 bits give 1.0
    '{ROW_WRITE, {bqf_pkg::REG_B0, 2'b00}, 32'hABCC_4000, '0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sd12345,    1'b1, 16'sd12345,    1'b0},
    // low 18 bits give -1.0
    '{ROW_WRITE, {bqf_pkg::REG_B0, 2'b00}, 32'h0003_C000, '0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sd1000,     1'b1, -16'sd1000,    1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh8000,     1'b1, 16'sh7FFF,     1'b1},
    // tiny b0 and a1 = -8.0: w runs away and clips while y stays small
    '{ROW_WRITE, {bqf_pkg::REG_B0, 2'b00}, 32'h0000_0001, '0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, {bqf_pkg::REG_A1, 2'b00}, 32'h0002_0000, '0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF,     1'b0, '0,            1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF,     1'b0, '0,            1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF,     1'b0, '0,            1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh8000,     1'b0, '0,            1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh8000,     1'b0, '0,            1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sd0,        1'b0, '0,            1'b0},
    // remaining coefficients at their limits
    '{ROW_WRITE, {bqf_pkg::REG_A2, 2'b00}, 32'h0001_FFFF, '0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, {bqf_pkg::REG_B1, 2'b00}, 32'h0001_FFFF, '0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, {bqf_pkg::REG_B2, 2'b00}, 32'h0002_0000, '0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh8000,     1'b0, '0,            1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sh7FFF,     1'b0, '0,            1'b0},
    '{ROW_SAMPLE, '0, '0, 16'sd0,        1'b0, '0,            1'b0}
  };

  logic  clk = 1'b0;
  logic  rst;
  logic  psel;
  logic  penable;
  logic  pwrite;
  addr_t paddr;
  data_t pwdata;
  data_t prdata;
  logic  pready;

  bqf_in_if  smp_if ();
  bqf_out_if res_if ();

  biquad_iir_filter dut (
    .clk,
    .rst,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .samples (smp_if),
    .results (res_if)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: coefficient shadow and the two delay taps
  bqf_pkg::coef_t coef_b0, coef_b1, coef_b2, fb_a1, fb_a2;
  bqf_pkg::wval_t w_d1, w_d2;

  filt_out_t filt_q [$];   // expected outputs, oldest first
  int        errors       = 0;
  int        tx_idle_pct  = 0;
  int        rx_stall_pct = 0;
  int        hold_len     = 0;
  logic      rx_hold      = 1'b0;

  // round half up at the coefficient binary point, then clamp to 'bits'
  function automatic longint round_clamp(input longint acc, input int bits,
                                         inout bit sat);
    longint hi, lo, r;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    r  = (acc + (longint'(1) <<< (bqf_pkg::COEFF_FRAC_BITS - 1)))
         >>> bqf_pkg::COEFF_FRAC_BITS;
    if (r > hi) begin
      sat = 1'b1;
      r   = hi;
    end else if (r < lo) begin
      sat = 1'b1;
      r   = lo;
    end
    return r;
  endfunction

  // one direct form II step; y uses the clamped w, delays shift afterwards
  function automatic filt_out_t filter_step(input smp_t x);
    longint    acc_w, acc_y, w;
    bit        sat;
    filt_out_t r;
    sat   = 1'b0;
    acc_w = longint'(x) * (longint'(1) <<< bqf_pkg::COEFF_FRAC_BITS)
          - longint'(fb_a1) * longint'(w_d1) - longint'(fb_a2) * longint'(w_d2);
    w     = round_clamp(acc_w, bqf_pkg::W_BITS, sat);
    acc_y = longint'(coef_b0) * w + longint'(coef_b1) * longint'(w_d1)
          + longint'(coef_b2) * longint'(w_d2);
    r.y    = smp_t'(round_clamp(acc_y, bqf_pkg::SAMPLE_BITS, sat));
    r.clip = sat;
    w_d2 = w_d1;
    w_d1 = bqf_pkg::wval_t'(w);
    return r;
  endfunction

  // mostly full-range noise, with rails and small values mixed in
  function automatic smp_t pick_sample();
    case ($urandom_range(19))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sd0;
      3:       return -16'sd1;
      4, 5, 6: return smp_t'(int'($urandom_range(512)) - 256);
      default: return smp_t'($urandom);
    endcase
  endfunction

  // APB write: setup, access (pready is tied high), then back to idle so
  // back-to-back writes never touch psel twice in one step
  task automatic write_coef_reg(input addr_t addr, input data_t data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    // shadow copy: only the low 18 bits count, unknown indexes are dropped
    case (addr[bqf_pkg::ADDR_BITS-1:2])
      bqf_pkg::REG_B0: coef_b0 = data[bqf_pkg::COEF_BITS-1:0];
      bqf_pkg::REG_B1: coef_b1 = data[bqf_pkg::COEF_BITS-1:0];
      bqf_pkg::REG_B2: coef_b2 = data[bqf_pkg::COEF_BITS-1:0];
      bqf_pkg::REG_A1: fb_a1   = data[bqf_pkg::COEF_BITS-1:0];
      bqf_pkg::REG_A2: fb_a2   = data[bqf_pkg::COEF_BITS-1:0];
      default: ;
    endcase
  endtask

  // Offer one sample request, with random idle cycles first. valid stays
  // high after acceptance; the next call or settle_filter decides its level.
  task automatic send_sample(input smp_t x, input bit typed, input smp_t ty,
                             input logic tclip);
    filt_out_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      smp_if.valid     <= 1'b0;
      smp_if.sample_in <= smp_t'($urandom);
      @(posedge clk);
    end
    smp_if.valid     <= 1'b1;
    smp_if.sample_in <= x;
    do @(posedge clk); while (!smp_if.ready);
    pred = filter_step(x);
    if (typed) begin
      pred.y    = ty;
      pred.clip = tclip;
    end
    filt_q.push_back(pred);
  endtask

  // wait for every outstanding request, then let the sequencer go idle
  task automatic settle_filter();
    smp_if.valid <= 1'b0;
    while (filt_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: score each accepted result, then pick ready for the next
  // edge. A long hold-off from the pressure process overrides the dice.
  // ---------------------------------------------------------------------------
  initial begin
    filt_out_t exp_out;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        if (filt_q.size() == 0) begin
          $error("sample_out: no request pending, got %0d", res_if.sample_out);
          errors++;
        end else begin
          exp_out = filt_q.pop_front();
          if (res_if.sample_out !== exp_out.y) begin
            $error("sample_out: expected %0d, got %0d", exp_out.y, res_if.sample_out);
            errors++;
          end
          if (res_if.clipped !== exp_out.clip) begin
            $error("clipped: expected %0d, got %0d", exp_out.clip, res_if.clipped);
            errors++;
          end
        end
      end
      if (rx_hold)
        res_if.ready <= 1'b0;
      else
        res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // receiver hold-off, counted here so the sender keeps pushing meanwhile
  initial begin
    wait (hold_len > 0);
    rx_hold <= 1'b1;
    repeat (hold_len) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, backpressure burst.
  // ---------------------------------------------------------------------------
  initial begin
    data_t val;
    int    coef_mode;

    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    smp_if.valid     = 1'b0;
    smp_if.sample_in = '0;

    // reset values of the shadow state
    coef_b0 = bqf_pkg::B0_RESET;
    coef_b1 = '0;
    coef_b2 = '0;
    fb_a1   = '0;
    fb_a2   = '0;
    w_d1    = '0;
    w_d2    = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed part: registers are only touched with the pipe empty
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        settle_filter();
        write_coef_reg(dir_tab[i].addr, dir_tab[i].data);
      end else begin
        send_sample(dir_tab[i].x, dir_tab[i].typed, dir_tab[i].y, dir_tab[i].clip);
      end
    end
    settle_filter();

    // random phases: idle mix steps every phase, coefficient style shifts
    // independently so each style meets more than one mix
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 60; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 60; end
        default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
      endcase
      coef_mode = (p + p / 4) % 4;
      for (int i = 0; i < bqf_pkg::NUM_REGS; i++) begin
        case (coef_mode)
          0: val = $urandom;                                   // any, upper bits junk
          1: val = 32'(int'($urandom_range(32768)) - 16384);   // within +-1.0
          2: begin                                             // rails and zero
            case ($urandom_range(2))
              0:       val = 32'h0001_FFFF;
              1:       val = 32'h0002_0000;
              default: val = '0;
            endcase
          end
          default: val = (i == bqf_pkg::REG_B0) ? 32'(bqf_pkg::B0_RESET) : '0;
        endcase
        write_coef_reg({bqf_pkg::IDX_BITS'(i), 2'b00}, val);
      end
      if (coef_mode == 0)
        write_coef_reg({($urandom_range(1) != 0) ? REG_NONE_HI : REG_NONE_LO, 2'b00},
                       $urandom);
      repeat (PHASE_ITEMS) send_sample(pick_sample(), 1'b0, '0, 1'b0);
      settle_filter();
    end

    // backpressure: receiver stops for a long stretch while requests keep
    // coming back to back, so the output register fills and input stalls
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_len     = HOLD_CYC;
    repeat (30) send_sample(pick_sample(), 1'b0, '0, 1'b0);
    settle_filter();

    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
